/* rtl/radar_can_message_decoder_defines.svh */
// Assertion macros used by the checker file.
`ifndef RADAR_CAN_MESSAGE_DECODER_DEFINES_SVH
`define RADAR_CAN_MESSAGE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rcmd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rcmd assertion failed");

`endif

/* rtl/rcmd_pkg.sv */
`timescale 1ns / 1ps
package rcmd_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CycW    = 32;
  localparam int unsigned StatusW = 24;
  localparam int unsigned FlagW   = 4;

  localparam logic [IdW-1:0] IdControl = 11'h500;
  localparam logic [IdW-1:0] IdHeader  = 11'h501;
  localparam logic [IdW-1:0] IdParam   = 11'h3F2;
  localparam logic [IdW-1:0] IdTrackLo = 11'h510;
  localparam logic [IdW-1:0] IdTrackHi = 11'h5FF;
  localparam logic [IdW-1:0] IdDiagLo  = 11'h700;
  localparam logic [IdW-1:0] IdDiagHi  = 11'h7C0;

  localparam logic [7:0] ScanLimitReset = 8'd60;
  localparam logic [6:0] SavedLimitReset = 7'd0;
  localparam logic [7:0] CanMaskReset   = 8'hFF;

  // Fault flag bit positions
  localparam int unsigned FlagCan   = 0;
  localparam int unsigned FlagObjs  = 1;
  localparam int unsigned FlagScan  = 2;
  localparam int unsigned FlagCycle = 3;

  typedef enum logic [2:0] {
    KIND_CONTROL = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_TRACK   = 3'd2,
    KIND_PARAM   = 3'd3,
    KIND_DIAG    = 3'd4,
    KIND_UNKNOWN = 3'd5
  } frame_kind_e;

  typedef enum logic [1:0] {
    CFG_SCAN_TIME_LIMIT    = 2'd0,
    CFG_SAVED_OBJECT_LIMIT = 2'd1,
    CFG_CAN_FAULT_MASK     = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [IdW-1:0]          frame_id;
    logic [7:0][ByteW-1:0]   data;      // data[k] is byte k
  } frame_t;

  typedef struct packed {
    logic [7:0] scan_time_limit;
    logic [6:0] saved_object_limit;
    logic [7:0] can_status_fault_mask;
  } cfg_t;

  typedef struct packed {
    logic [CycW-1:0] cycle_count;    // last latched header count
    logic [PosW-1:0] list_position;  // slot the next track takes
  } list_state_t;

  typedef struct packed {
    logic            header;
    logic            track;
    logic [CycW-1:0] cycle_count;
  } list_update_t;

  typedef struct packed {
    frame_kind_e        frame_kind;
    logic [5:0]         object_id;
    logic signed [13:0] x_range;
    logic signed [13:0] y_range;
    logic signed [10:0] x_velocity;
    logic signed [10:0] y_velocity;
    logic [7:0]         object_length;
    logic [PosW-1:0]    list_position;
    logic [CycW-1:0]    cycle_count;
    logic [CycW-1:0]    header_word;
    logic [StatusW-1:0] status_word;
    logic [FlagW-1:0]   fault_flags;
  } result_t;

endpackage

/* rtl/radar_can_message_decoder.sv */
`timescale 1ns / 1ps
// Radar CAN frame decoder. Each transfer on the slave stream carries one CAN
// frame (11-bit identifier and eight data bytes) and produces exactly one
// transfer on the master stream that gives the frame's kind on tuser and the
// unpacked fields on tdata. The block takes one frame per clock cycle while the
// output is not stalled; a frame passes through two registers (input register,
// then result register) with a combinational decode between them. s_axis_tready
// follows m_axis_tready combinationally, so a stalled output holds back the
// input only once both registers are full. Header frames restart the track
// list and latch the scan cycle count; track frames take the next list slot,
// saturating at LIST_SLOTS. Write configuration registers only while no frame
// is in flight.
module radar_can_message_decoder
  import rcmd_pkg::*;
#(
  parameter int unsigned LIST_SLOTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Frame input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [10:0] frame_id, [18:11] byte0, [26:19] byte1, [34:27] byte2,
  // [42:35] byte3, [50:43] byte4, [58:51] byte5, [66:59] byte6,
  // [74:67] byte7, [79:75] zero
  input  logic [79:0]  s_axis_tdata,
  // Decoded result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] object_id, [19:6] x_range, [33:20] y_range, [44:34] x_velocity,
  // [55:45] y_velocity, [63:56] object_length, [70:64] list_position,
  // [102:71] cycle_count, [134:103] header_word, [158:135] status_word,
  // [162:159] fault_flags, [167:163] zero
  output logic [167:0] m_axis_tdata,
  // [2:0] frame_kind
  output logic [2:0]   m_axis_tuser,
  // Configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  logic         in_valid_q, in_valid_d;
  frame_t       in_frame_q;
  logic         out_valid_q, out_valid_d;
  result_t      out_q;
  logic         advance;
  cfg_t         cfg;
  list_state_t  list_state;
  list_update_t list_update;
  result_t      result;
  frame_t       s_frame;

  // Unpack the input stream word into the frame record.
  always_comb begin
    s_frame.frame_id = s_axis_tdata[IdW-1:0];
    for (int k = 0; k < 8; k++) begin
      s_frame.data[k] = s_axis_tdata[IdW + ByteW*k +: ByteW];
    end
  end

  // Advance when the input register holds a frame and the result register is
  // free or being drained this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_frame_q <= s_frame;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Configuration is always accepted; the user writes it only while idle, unenforced here.
  assign cfg_ready_o = 1'b1;

  rcmd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // List state updates in frame order as each frame leaves the input register.
  rcmd_list_state #(
    .LIST_SLOTS (LIST_SLOTS)
  ) u_list_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .update_valid_i (advance),
    .update_i       (list_update),
    .state_o        (list_state)
  );

  rcmd_decode u_decode (
    .frame_i  (in_frame_q),
    .cfg_i    (cfg),
    .state_i  (list_state),
    .result_o (result),
    .update_o (list_update)
  );

  // Drive the master stream from the result register.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.frame_kind;
  assign m_axis_tdata  = {5'd0,
                          out_q.fault_flags,
                          out_q.status_word,
                          out_q.header_word,
                          out_q.cycle_count,
                          out_q.list_position,
                          out_q.object_length,
                          out_q.y_velocity,
                          out_q.x_velocity,
                          out_q.y_range,
                          out_q.x_range,
                          out_q.object_id};

endmodule

/* rtl/rcmd_cfg_regs.sv */
`timescale 1ns / 1ps
module rcmd_cfg_regs
  import rcmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCAN_TIME_LIMIT:    cfg_d.scan_time_limit       = cfg_data_i;
        CFG_SAVED_OBJECT_LIMIT: cfg_d.saved_object_limit    = cfg_data_i[6:0];
        CFG_CAN_FAULT_MASK:     cfg_d.can_status_fault_mask = cfg_data_i;
        default:                cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_time_limit       <= ScanLimitReset;
      cfg_q.saved_object_limit    <= SavedLimitReset;
      cfg_q.can_status_fault_mask <= CanMaskReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/rcmd_list_state.sv */
`timescale 1ns / 1ps
module rcmd_list_state
  import rcmd_pkg::*;
#(
  parameter int unsigned LIST_SLOTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         update_valid_i,
  input  list_update_t update_i,
  output list_state_t  state_o
);

  localparam int unsigned SlotW = $clog2(LIST_SLOTS + 1);
  localparam logic [SlotW-1:0] SlotMax = SlotW'(LIST_SLOTS);

  // Previous and current cycle counts always move together, so one register
  // serves both.
  logic [CycW-1:0]  cycle_q, cycle_d;
  logic [SlotW-1:0] slot_q, slot_d;

  always_comb begin
    cycle_d = cycle_q;
    slot_d  = slot_q;
    if (update_valid_i && update_i.header) begin
      cycle_d = update_i.cycle_count;
      slot_d  = '0;
    end else if (update_valid_i && update_i.track && (slot_q < SlotMax)) begin
      slot_d = slot_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= '0;
      slot_q  <= '0;
    end else begin
      cycle_q <= cycle_d;
      slot_q  <= slot_d;
    end
  end

  assign state_o.cycle_count   = cycle_q;
  assign state_o.list_position = PosW'(slot_q);

endmodule

/* rtl/rcmd_decode.sv */
`timescale 1ns / 1ps
module rcmd_decode
  import rcmd_pkg::*;
(
  input  frame_t       frame_i,
  input  cfg_t         cfg_i,
  input  list_state_t  state_i,
  output result_t      result_o,
  output list_update_t update_o
);

  logic [7:0][7:0] b;
  logic [CycW-1:0] lo_word, hi_word;
  logic [13:0]     xr, yr;
  logic [10:0]     xv, yv;

  assign b       = frame_i.data;
  assign lo_word = {b[3], b[2], b[1], b[0]};
  assign hi_word = {b[7], b[6], b[5], b[4]};
  assign xr      = {b[1][5:0], b[0]};
  assign yr      = {b[3][3:0], b[2], b[1][7:6]};
  assign xv      = {b[4][6:0], b[3][7:4]};
  assign yv      = {b[6][1:0], b[5], b[4][7]};

  always_comb begin
    result_o             = '0;
    result_o.frame_kind  = KIND_UNKNOWN;
    result_o.cycle_count = state_i.cycle_count;
    update_o             = '0;
    update_o.cycle_count = hi_word;

    if (frame_i.frame_id == IdControl) begin
      result_o.frame_kind           = KIND_CONTROL;
      result_o.header_word          = hi_word;
      result_o.status_word          = {b[1], b[3], b[2]};
      result_o.fault_flags[FlagCan] = |(b[1] & cfg_i.can_status_fault_mask);
    end else if (frame_i.frame_id == IdHeader) begin
      result_o.frame_kind  = KIND_HEADER;
      result_o.header_word = lo_word;
      result_o.cycle_count = hi_word;
      result_o.fault_flags[FlagObjs]  = b[0] > {1'b0, cfg_i.saved_object_limit};
      result_o.fault_flags[FlagScan]  = b[2] >= cfg_i.scan_time_limit;
      // Modulo-2^32 step check against the last latched count
      result_o.fault_flags[FlagCycle] = (hi_word - state_i.cycle_count) != CycW'(1);
      update_o.header = 1'b1;
    end else if (frame_i.frame_id == IdParam) begin
      result_o.frame_kind  = KIND_PARAM;
      result_o.header_word = hi_word;
      result_o.status_word = {8'h00, b[2], b[1]};
    end else if (frame_i.frame_id inside {[IdTrackLo:IdTrackHi]}) begin
      // Offset binary to two's complement: flip the top bit
      result_o.frame_kind    = KIND_TRACK;
      result_o.object_id     = b[7][7:2];
      result_o.x_range       = {~xr[13], xr[12:0]};
      result_o.y_range       = {~yr[13], yr[12:0]};
      result_o.x_velocity    = {~xv[10], xv[9:0]};
      result_o.y_velocity    = {~yv[10], yv[9:0]};
      result_o.object_length = {b[7][1:0], b[6][7:2]};
      result_o.list_position = state_i.list_position;
      update_o.track         = 1'b1;
    end else if (frame_i.frame_id inside {[IdDiagLo:IdDiagHi]}) begin
      result_o.frame_kind = KIND_DIAG;
    end
  end

endmodule

/* rtl/rcmd_checker.sv */
`timescale 1ns / 1ps
`include "radar_can_message_decoder_defines.svh"
module rcmd_checker
  import rcmd_pkg::*;
#(
  parameter int unsigned LIST_SLOTS = 64
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  logic is_track, is_control, is_header;

  assign is_track   = m_axis_tuser == KIND_TRACK;
  assign is_control = m_axis_tuser == KIND_CONTROL;
  assign is_header  = m_axis_tuser == KIND_HEADER;

  // A stalled result holds its valid and its contents.
  `RCMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Track fields are zero outside track results.
  `RCMD_ASSERT_NOW(a_track_fields_zero, clk_i, rst_ni, m_axis_tvalid && !is_track, m_axis_tdata[70:0] == '0)

  // List position never passes the list size.
  `RCMD_ASSERT_NOW(a_pos_bound, clk_i, rst_ni, m_axis_tvalid && is_track, m_axis_tdata[70:64] <= 7'(LIST_SLOTS))

  // Faults come only from control (CAN status) and header frames.
  `RCMD_ASSERT_NOW(a_fault_source, clk_i, rst_ni, m_axis_tvalid && !is_header, m_axis_tdata[162:160] == '0 && (is_control || !m_axis_tdata[159]))

endmodule

bind radar_can_message_decoder rcmd_checker #(
  .LIST_SLOTS (LIST_SLOTS)
) u_rcmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
